>>> rtl/can_acf_pkg.sv
// Shared types and constants for the CAN receive acceptance filter.
// No dependencies; imported by every module of the block.
package can_acf_pkg;

    localparam int FILTER_ENTRIES = 16;
    localparam int IDX_W  = (FILTER_ENTRIES > 1) ? $clog2(FILTER_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(FILTER_ENTRIES + 1);
    localparam int WORD_W = 12;

    localparam logic [WORD_W-1:0] MASK_RESET = 12'hFFF;
    localparam logic [WORD_W-1:0] IDENT_RESET = 12'h000;

    localparam logic MODE_PROGRAM = 1'b0;
    localparam logic MODE_FRAME   = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [7:0]  entry_index;
        logic [10:0] filter_ident;
        logic [10:0] filter_mask;
        logic        filter_rtr;
        logic [10:0] frame_id;
        logic        frame_rtr;
        logic [3:0]  frame_dlc;
        logic [63:0] frame_data;
    } t_in_item;

    typedef struct packed {
        logic        program_ok;
        logic        frame_hit;
        logic        frame_delivered;
        logic [3:0]  hit_index;
        logic [10:0] out_id;
        logic        out_rtr;
        logic [3:0]  out_dlc;
        logic [63:0] out_data;
    } t_out_item;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
        logic              hit;
        logic [IDX_W-1:0]  idx;
        logic              prog;
    } t_token;

    // Entry write broadcast to all cells.
    typedef struct packed {
        logic [WORD_W-1:0] ident;
        logic [WORD_W-1:0] mask;
    } t_entry_wr;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } t_state;

endpackage

>>> rtl/can_acf_cell.sv
// One filter entry of the chain: stores identifier, mask and programmed flag,
// and checks the passing search token. Depends on can_acf_pkg.
module can_acf_cell
    import can_acf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_cell_idx,
    input  logic             i_active,
    input  logic             i_wr_en,
    input  t_entry_wr        i_wr,
    input  t_token           i_tok,
    output t_token           o_tok
);

    logic [WORD_W-1:0] r_ident;
    logic [WORD_W-1:0] r_mask;
    logic              r_prog;
    t_token            r_tok;
    t_token            n_tok;
    logic              w_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ident <= IDENT_RESET;
            r_mask  <= MASK_RESET;
            r_prog  <= 1'b0;
        end else if (i_wr_en) begin
            r_ident <= i_wr.ident;
            r_mask  <= i_wr.mask;
            r_prog  <= 1'b1;
        end
    end

    assign w_match = ((i_tok.word ^ r_ident) & r_mask) == '0;

    // Only the first active match claims the token.
    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && !i_tok.hit && i_active && w_match) begin
            n_tok.hit  = 1'b1;
            n_tok.idx  = i_cell_idx;
            n_tok.prog = r_prog;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.word <= n_tok.word;
        r_tok.hit  <= n_tok.hit;
        r_tok.idx  <= n_tok.idx;
        r_tok.prog <= n_tok.prog;
    end

    assign o_tok = r_tok;

endmodule

>>> rtl/can_rx_acceptance_filter_core.sv
// Top level of the CAN receive acceptance filter: item handshakes, entry
// programming, result register and the chain of filter cells.
// Depends on can_acf_pkg and can_acf_cell.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready, i_in_item) carries program items
//   (mode 0) and received frames (mode 1). Output channel (o_out_valid /
//   i_out_ready, o_out_item) returns exactly one result item per input item.
//   Configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_data) sets the
//   number of entries in use; write it only while the block is idle.
// Sequencing and throughput:
//   A program item writes its entry in the accept cycle; its result is
//   valid the next cycle, and a new item may follow every cycle while
//   the output register is free. A frame item walks the search token
//   through one cell per cycle into the finish register; the result then
//   moves to the output register once that register is free, and the
//   next item is taken only after that move.
// Reset:
//   All entries return to identifier 0, mask all ones, not programmed;
//   entries in use returns to 16. No clearing pass is needed.
// Stall:
//   While a result waits on i_out_ready, a finished frame result is parked
//   and no new item is accepted until the output register frees up.
module can_rx_acceptance_filter_core
    import can_acf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [4:0] i_cfg_data
);

    logic [4:0]       r_entries;
    logic [CNT_W-1:0] w_count;
    t_state           r_state;
    t_state           n_state;
    logic             w_in_ready;
    logic             w_in_acc;
    logic             w_out_free;
    logic             w_prog_ok;
    logic             w_prog_item;
    logic             w_frame_item;
    logic             w_load_frame;
    t_entry_wr        w_wr;
    t_token           w_tok [FILTER_ENTRIES+1];
    logic [FILTER_ENTRIES-1:0] w_wr_en;
    logic [FILTER_ENTRIES-1:0] w_active;
    t_token           r_fin;
    t_in_item         r_frame;
    logic             r_out_valid;
    t_out_item        r_out_item;
    t_out_item        w_prog_res;
    t_out_item        w_frame_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= 5'd16;
        end else if (i_cfg_valid) begin
            r_entries <= i_cfg_data;
        end
    end

    // Saturate the configured count at the bank size.
    always_comb begin
        if (32'(r_entries) < FILTER_ENTRIES) begin
            w_count = CNT_W'(r_entries);
        end else begin
            w_count = CNT_W'(FILTER_ENTRIES);
        end
    end

    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_in_acc     = i_in_valid && w_in_ready;
    assign w_prog_item  = w_in_acc && (i_in_item.mode == MODE_PROGRAM);
    assign w_frame_item = w_in_acc && (i_in_item.mode == MODE_FRAME);
    assign w_prog_ok    = 32'(i_in_item.entry_index) < 32'(w_count);
    assign o_in_ready   = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        w_in_ready   = 1'b0;
        w_load_frame = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_in_ready = w_out_free;
                if (w_frame_item) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_tok[FILTER_ENTRIES].valid) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (w_out_free) begin
                    w_load_frame = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_wr.ident = {i_in_item.filter_rtr, i_in_item.filter_ident};
    assign w_wr.mask  = {1'b1, i_in_item.filter_mask};

    // Inject the search token in the accept cycle.
    always_comb begin
        w_tok[0].valid = w_frame_item;
        w_tok[0].word  = {i_in_item.frame_rtr, i_in_item.frame_id};
        w_tok[0].hit   = 1'b0;
        w_tok[0].idx   = '0;
        w_tok[0].prog  = 1'b0;
    end

    for (genvar g = 0; g < FILTER_ENTRIES; g++) begin : g_cell
        assign w_active[g] = 32'(g) < 32'(w_count);
        assign w_wr_en[g]  = w_prog_item && w_prog_ok &&
                             (i_in_item.entry_index[IDX_W-1:0] == IDX_W'(g));

        can_acf_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (IDX_W'(g)),
            .i_active   (w_active[g]),
            .i_wr_en    (w_wr_en[g]),
            .i_wr       (w_wr),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_frame_item) begin
            r_frame <= i_in_item;
        end
        if (r_state == ST_SCAN && w_tok[FILTER_ENTRIES].valid) begin
            r_fin <= w_tok[FILTER_ENTRIES];
        end
    end

    always_comb begin
        w_prog_res            = '0;
        w_prog_res.program_ok = w_prog_ok;

        w_frame_res           = '0;
        w_frame_res.frame_hit = r_fin.hit;
        if (r_fin.hit) begin
            w_frame_res.hit_index = 4'(r_fin.idx);
        end
        if (r_fin.hit && r_fin.prog) begin
            w_frame_res.frame_delivered = 1'b1;
            w_frame_res.out_id          = r_frame.frame_id;
            w_frame_res.out_rtr         = r_frame.frame_rtr;
            w_frame_res.out_dlc         = r_frame.frame_dlc;
            w_frame_res.out_data        = r_frame.frame_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_prog_item || w_load_frame) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_prog_item) begin
            r_out_item <= w_prog_res;
        end else if (w_load_frame) begin
            r_out_item <= w_frame_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> rtl/can_acf_checker.sv
// Port-level checks for can_rx_acceptance_filter_core, bound to the top.
// Depends on can_acf_pkg.
module can_acf_checker
    import can_acf_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result item changed");

    a_no_take_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("item accepted while result register is stalled");

    a_deliver_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.frame_delivered |->
            o_out_item.frame_hit && !o_out_item.program_ok)
        else $error("delivery without hit or on program item");

    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.frame_delivered |->
            o_out_item.out_data == '0 && o_out_item.out_id == '0 &&
            (o_out_item.frame_hit || o_out_item.hit_index == '0))
        else $error("undelivered result carries frame fields");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind can_rx_acceptance_filter_core can_acf_checker u_can_acf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

>>> sim/tb_top.sv
// Self-checking testbench for can_rx_acceptance_filter_core.
// Holds its own filter bank predictor and result scoreboard; depends on can_acf_pkg
// and the core RTL only.
module tb_top
    import can_acf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 8;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;
    localparam int IN_W           = $bits(t_in_item);
    localparam logic [10:0] ID_ALL = 11'h7FF;

    // Predicts one result per item from a private copy of the filter bank.
    class filter_bank_model;
        logic [11:0] ident_word [FILTER_ENTRIES];
        logic [11:0] mask_word [FILTER_ENTRIES];
        bit          programmed [FILTER_ENTRIES];
        logic [4:0]  entries_in_use;
        t_out_item   pending_results [$];
        int          mismatches;
        int          results_seen;

        function new();
            for (int k = 0; k < FILTER_ENTRIES; k++) begin
                ident_word[k] = IDENT_RESET;
                mask_word[k]  = MASK_RESET;
                programmed[k] = 1'b0;
            end
            entries_in_use = 5'd16;
            mismatches     = 0;
            results_seen   = 0;
        endfunction

        function int active_count();
            return (entries_in_use < FILTER_ENTRIES) ? int'(entries_in_use) : FILTER_ENTRIES;
        endfunction

        function void set_count(logic [4:0] value);
            entries_in_use = value;
        endfunction

        function void note_item(t_in_item it);
            t_out_item   r;
            logic [11:0] word;
            int          count;
            int          k;
            bit          found;
            r     = '0;
            count = active_count();
            found = 1'b0;
            if (it.mode == MODE_PROGRAM) begin
                if (int'(it.entry_index) < count) begin
                    ident_word[it.entry_index] = {it.filter_rtr, it.filter_ident};
                    mask_word[it.entry_index]  = {1'b1, it.filter_mask};
                    programmed[it.entry_index] = 1'b1;
                    r.program_ok = 1'b1;
                end
            end else begin
                word = {it.frame_rtr, it.frame_id};
                for (k = 0; k < count && !found; k++) begin
                    if (((word ^ ident_word[k]) & mask_word[k]) == '0) begin
                        found       = 1'b1;
                        r.frame_hit = 1'b1;
                        r.hit_index = k[3:0];
                        if (programmed[k]) begin
                            r.frame_delivered = 1'b1;
                            r.out_id   = it.frame_id;
                            r.out_rtr  = it.frame_rtr;
                            r.out_dlc  = it.frame_dlc;
                            r.out_data = it.frame_data;
                        end
                    end
                end
            end
            pending_results.push_back(r);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%s", msg);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
                flag($sformatf("result %0d, %s: expected 0x%0h, got 0x%0h",
                               results_seen, name, want, got));
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                flag($sformatf("result %0d arrived with nothing pending", results_seen));
            end else begin
                want = pending_results.pop_front();
                compare_field("program_ok", 64'(want.program_ok), 64'(got.program_ok));
                compare_field("frame_hit", 64'(want.frame_hit), 64'(got.frame_hit));
                compare_field("frame_delivered", 64'(want.frame_delivered),
                              64'(got.frame_delivered));
                compare_field("hit_index", 64'(want.hit_index), 64'(got.hit_index));
                compare_field("out_id", 64'(want.out_id), 64'(got.out_id));
                compare_field("out_rtr", 64'(want.out_rtr), 64'(got.out_rtr));
                compare_field("out_dlc", 64'(want.out_dlc), 64'(got.out_dlc));
                compare_field("out_data", want.out_data, got.out_data);
            end
            results_seen++;
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_item   i_in_item;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_item  o_out_item;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [4:0] i_cfg_data;

    filter_bank_model bank = new();
    bit hold_request = 1'b0;
    bit no_idle      = 1'b0;
    int stall_cycles;

    can_rx_acceptance_filter_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            bank.check_result(o_out_item);
    end

    function automatic t_in_item prog_item(logic [7:0] idx, logic [10:0] id,
                                           logic [10:0] msk, logic rtr);
        t_in_item it;
        it = IN_W'({$urandom, $urandom, $urandom, $urandom});
        it.mode         = MODE_PROGRAM;
        it.entry_index  = idx;
        it.filter_ident = id;
        it.filter_mask  = msk;
        it.filter_rtr   = rtr;
        return it;
    endfunction

    function automatic t_in_item frame_item(logic [10:0] id, logic rtr, logic [3:0] dlc,
                                            logic [63:0] data);
        t_in_item it;
        it = IN_W'({$urandom, $urandom, $urandom, $urandom});
        it.mode       = MODE_FRAME;
        it.frame_id   = id;
        it.frame_rtr  = rtr;
        it.frame_dlc  = dlc;
        it.frame_data = data;
        return it;
    endfunction

    // Hold the item on the bus until it is taken, then note it for prediction.
    task automatic send_item(input t_in_item it);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        bank.note_item(it);
    endtask

    // Drain all pending results, let the scan settle, then write entries_in_use.
    task automatic write_count(input logic [4:0] value);
        while (bank.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (FILTER_ENTRIES + 4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        bank.set_count(value);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int n_items, input int hold_at);
        t_in_item it;
        int       n;
        int       k;
        int       act;
        int       pick;
        bit       gaps_on;
        gaps_on = 1'b1;
        for (n = 0; n < n_items; n++) begin
            if (n % 50 == 0)
                gaps_on = ($urandom_range(0, 2) != 0);
            if (n == hold_at)
                hold_request = 1'b1;
            it = IN_W'({$urandom, $urandom, $urandom, $urandom});
            act = bank.active_count();
            if ($urandom_range(0, 9) < 4) begin
                it.mode = MODE_PROGRAM;
                if ($urandom_range(0, 4) != 0)
                    it.entry_index = 8'($urandom_range(0, act));
                case ($urandom_range(0, 3))
                    1: it.filter_mask = ID_ALL;
                    2: it.filter_mask = '0;
                    3: it.filter_mask = it.filter_mask | 11'($urandom);
                    default: ;
                endcase
            end else begin
                it.mode = MODE_FRAME;
                pick = $urandom_range(0, 19);
                if (pick < 11) begin
                    // aim at an entry: vary only the bits its mask ignores
                    k = $urandom_range(0, FILTER_ENTRIES - 1);
                    it.frame_id  = bank.ident_word[k][10:0] ^
                                   (11'($urandom) & ~bank.mask_word[k][10:0]);
                    it.frame_rtr = bank.ident_word[k][11];
                end else if (pick < 13) begin
                    it.frame_id  = '0;
                    it.frame_rtr = 1'b0;
                end
                case ($urandom_range(0, 15))
                    0: it.frame_data = '0;
                    1: it.frame_data = '1;
                    default: ;
                endcase
            end
            if (!no_idle && gaps_on && $urandom_range(0, 3) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            send_item(it);
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic directed_phase();
        send_item(frame_item('0, 1'b0, 4'h0, '0));
        send_item(frame_item(ID_ALL, 1'b1, 4'hF, '1));
        send_item(prog_item(8'd15, ID_ALL, ID_ALL, 1'b1));
        send_item(frame_item(ID_ALL, 1'b1, 4'hF, '1));
        send_item(frame_item(11'h7FE, 1'b1, 4'h3, 64'h0123_4567_89AB_CDEF));
        send_item(prog_item(8'd16, 11'h155, 11'h2AA, 1'b0));
        send_item(prog_item(8'd255, ID_ALL, ID_ALL, 1'b1));
        send_item(prog_item(8'd3, 11'h155, '0, 1'b0));
        send_item(frame_item(11'h2AA, 1'b0, 4'h8, 64'hFEDC_BA98_7654_3210));
        send_item(frame_item('0, 1'b0, 4'h1, 64'hA5));
        send_item(prog_item(8'd0, '0, ID_ALL, 1'b0));
        send_item(frame_item('0, 1'b0, 4'h0, '0));
        send_item(frame_item(ID_ALL, 1'b0, 4'hF, '1));
        send_item(prog_item(8'd1, ID_ALL, '0, 1'b1));
        send_item(frame_item(11'h3C3, 1'b1, 4'h0, '0));
        send_item(prog_item(8'd2, 11'h0F0, 11'h0F0, 1'b0));
        send_item(frame_item(11'h0F5, 1'b0, 4'h2, 64'hBEEF));
        send_item(frame_item(11'h00F, 1'b0, 4'h4, 64'h1234_5678));
        send_item(prog_item(8'd0, ID_ALL, ID_ALL, 1'b1));
        send_item(frame_item(ID_ALL, 1'b1, 4'h7, 64'h8000_0000_0000_0001));
        i_in_valid <= 1'b0;
    endtask

    // Receiver: random stall bursts, quiet stretches, and one long hold-off on request.
    initial begin
        bit quiet_stretch;
        quiet_stretch = 1'b0;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 127) == 0)
                quiet_stretch = !quiet_stretch;
            if (hold_request) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_request = 1'b0;
            end else if (!no_idle && !quiet_stretch && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Watchdog: end the run when nothing moves on any channel for too long.
    initial begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_phase();
        write_count(5'd0);
        random_phase(40, -1);
        write_count(5'd1);
        random_phase(120, -1);
        write_count(5'd31);
        random_phase(250, 100);
        write_count(5'd5);
        random_phase(250, -1);
        write_count(5'd17);
        random_phase(200, -1);
        write_count(5'd16);
        random_phase(260, -1);
        no_idle = 1'b1;
        random_phase(200, -1);

        while (bank.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (FILTER_ENTRIES + 8) @(posedge i_clk);
        if (bank.mismatches == 0 && bank.pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
rtl/can_acf_pkg.sv
rtl/can_acf_cell.sv
rtl/can_rx_acceptance_filter_core.sv
rtl/can_acf_checker.sv
sim/tb_top.sv
